>>> hdl/dvrs_pkg.sv
// Shared types and constants for the distance-vector route solver.
// Used by the relaxation engine and the top level.
package dvrs_pkg;

  // Table geometry and cost width
  localparam int MAX_NODES  = 32;
  localparam int NODE_BITS  = $clog2(MAX_NODES);
  localparam int CNT_BITS   = NODE_BITS + 1;
  localparam int COST_BITS  = 10;
  localparam int ADDR_BITS  = 2 * NODE_BITS;
  localparam int CELLS      = MAX_NODES * MAX_NODES;
  localparam int ROUTE_BITS = 1 + NODE_BITS + COST_BITS;

  // Request payload widths
  localparam int IN_BITS  = 24;
  localparam int OUT_BITS = 24;

  // Action codes of an input request
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_COMPUTE = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;

  // Status codes of a result
  localparam logic [1:0] STS_WRITTEN   = 2'd0;
  localparam logic [1:0] STS_CONVERGED = 2'd1;
  localparam logic [1:0] STS_ANSWER    = 2'd2;

  // Configuration register indexes
  localparam logic CFG_NODE_COUNT  = 1'b0;
  localparam logic CFG_UNREACHABLE = 1'b1;

  // One routing table entry: best cost plus next hop
  typedef struct packed {
    logic                 valid;
    logic [NODE_BITS-1:0] hop;
    logic [COST_BITS-1:0] cost;
  } route_t;

  // Memory port requests issued by the relaxation engine
  typedef struct packed {
    logic                 link_re;
    logic [ADDR_BITS-1:0] link_raddr;
    logic                 route_re;
    logic [ADDR_BITS-1:0] route_raddr;
    logic                 route_we;
    logic [ADDR_BITS-1:0] route_waddr;
    route_t               route_wdata;
  } mem_req_t;

endpackage

>>> hdl/dvrs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dvrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and register the read word; hold it while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/dvrs_engine.sv
// Relaxation engine: builds the routing table from the link matrix, then
// relaxes it pass by pass until nothing changes. Depends on dvrs_pkg.
module dvrs_engine
  import dvrs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CNT_BITS-1:0]  node_count_i,
  input  logic [COST_BITS-1:0] unreach_i,
  input  logic [COST_BITS-1:0] link_rdata_i,
  input  route_t               route_rdata_i,
  output mem_req_t             req_o,
  output logic                 done_o
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_INIT,
    E_IDRAIN,
    E_RLOAD,
    E_RSCAN,
    E_RDRAIN,
    E_RWRITE
  } eng_state_e;

  eng_state_e           state_q, state_d;
  logic [NODE_BITS-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [NODE_BITS-1:0] last_q, last_d;
  logic                 pv_q, pv_d;
  logic [NODE_BITS-1:0] pk_q, pk_d;
  logic                 ld_q, ld_d;
  logic                 iw_q, iw_d;
  logic [ADDR_BITS-1:0] iwa_q, iwa_d;
  route_t               cur_q, cur_d;
  logic                 chg_q, chg_d;
  logic                 done_q, done_d;

  logic [CNT_BITS-1:0]  n_eff;
  logic                 hop_ok;
  logic [COST_BITS-1:0] b_cost;
  logic [COST_BITS:0]   sum;
  logic                 take;
  logic                 j_end, i_end;

  // Clamp the node count to the table size
  assign n_eff = (node_count_i > CNT_BITS'(MAX_NODES)) ? CNT_BITS'(MAX_NODES) : node_count_i;

  // Initial hop: the destination itself when a link exists off the diagonal
  assign hop_ok = (link_rdata_i != unreach_i) &&
                  (iwa_q[ADDR_BITS-1:NODE_BITS] != iwa_q[NODE_BITS-1:0]);

  // Candidate sum; the current cell is forwarded when the neighbor is the source
  assign b_cost = (pk_q == i_q) ? cur_q.cost : route_rdata_i.cost;
  assign sum    = {1'b0, link_rdata_i} + {1'b0, b_cost};
  assign take   = pv_q && (link_rdata_i != unreach_i) && (b_cost != unreach_i) &&
                  ({1'b0, cur_q.cost} > sum);

  assign j_end = (j_q == last_q);
  assign i_end = (i_q == last_q);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    last_d  = last_q;
    pv_d    = 1'b0;
    pk_d    = pk_q;
    ld_d    = 1'b0;
    iw_d    = 1'b0;
    iwa_d   = iwa_q;
    cur_d   = cur_q;
    chg_d   = chg_q;
    done_d  = 1'b0;
    req_o   = '0;

    // Write back one initial entry in the cycle after its link read
    if (iw_q) begin
      req_o.route_we          = 1'b1;
      req_o.route_waddr       = iwa_q;
      req_o.route_wdata.cost  = link_rdata_i;
      req_o.route_wdata.valid = hop_ok;
      req_o.route_wdata.hop   = hop_ok ? iwa_q[NODE_BITS-1:0] : '0;
    end

    // Capture the cell under relaxation
    if (ld_q) begin
      cur_d = route_rdata_i;
    end

    // Take a strictly lower sum through neighbor pk
    if (take) begin
      cur_d.cost  = sum[COST_BITS-1:0];
      cur_d.hop   = pk_q;
      cur_d.valid = 1'b1;
      chg_d       = 1'b1;
    end

    unique case (state_q)
      E_IDLE: begin
        if (start_i) begin
          if (n_eff == '0) begin
            done_d = 1'b1;
          end else begin
            last_d  = NODE_BITS'(n_eff - CNT_BITS'(1));
            i_d     = '0;
            j_d     = '0;
            state_d = E_INIT;
          end
        end
      end
      E_INIT: begin
        req_o.link_re    = 1'b1;
        req_o.link_raddr = {i_q, j_q};
        iw_d             = 1'b1;
        iwa_d            = {i_q, j_q};
        if (j_end) begin
          j_d = '0;
          if (i_end) begin
            i_d     = '0;
            state_d = E_IDRAIN;
          end else begin
            i_d = i_q + NODE_BITS'(1);
          end
        end else begin
          j_d = j_q + NODE_BITS'(1);
        end
      end
      E_IDRAIN: begin
        chg_d   = 1'b0;
        state_d = E_RLOAD;
      end
      E_RLOAD: begin
        req_o.route_re    = 1'b1;
        req_o.route_raddr = {i_q, j_q};
        ld_d              = 1'b1;
        k_d               = '0;
        state_d           = E_RSCAN;
      end
      E_RSCAN: begin
        req_o.link_re     = 1'b1;
        req_o.link_raddr  = {i_q, k_q};
        req_o.route_re    = 1'b1;
        req_o.route_raddr = {k_q, j_q};
        pv_d              = 1'b1;
        pk_d              = k_q;
        if (k_q == last_q) begin
          state_d = E_RDRAIN;
        end else begin
          k_d = k_q + NODE_BITS'(1);
        end
      end
      E_RDRAIN: begin
        state_d = E_RWRITE;
      end
      E_RWRITE: begin
        req_o.route_we    = 1'b1;
        req_o.route_waddr = {i_q, j_q};
        req_o.route_wdata = cur_q;
        state_d           = E_RLOAD;
        if (j_end) begin
          j_d = '0;
          if (i_end) begin
            i_d = '0;
            // Repeat the pass while anything changed
            if (chg_q) begin
              chg_d = 1'b0;
            end else begin
              done_d  = 1'b1;
              state_d = E_IDLE;
            end
          end else begin
            i_d = i_q + NODE_BITS'(1);
          end
        end else begin
          j_d = j_q + NODE_BITS'(1);
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      pv_q    <= 1'b0;
      ld_q    <= 1'b0;
      iw_q    <= 1'b0;
      chg_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
      ld_q    <= ld_d;
      iw_q    <= iw_d;
      chg_q   <= chg_d;
      done_q  <= done_d;
    end
  end

  // Counters and datapath
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    last_q <= last_d;
    pk_q   <= pk_d;
    iwa_q  <= iwa_d;
    cur_q  <= cur_d;
  end

  assign done_o = done_q;

endmodule

>>> hdl/distance_vector_route_solver.sv
// Top level of the distance-vector route solver: request decode, query path,
// configuration registers and result register. Depends on dvrs_pkg,
// dvrs_ram and dvrs_engine.
//
// Usage: requests enter on s_axis_*, one result leaves on m_axis_* for each
// write, compute or query request; action 3 is taken and dropped.
// A write stores one link cost and presents its result; the next request can be
// taken only once that result has moved into the result register. A query
// reads the routing table and presents its result.
// A compute builds the table from the link matrix over the clamped node count,
// then relaxes it in passes until a pass changes nothing; one neighbor is tried
// per cycle, set by the single read port of the routing table memory. A node
// count of zero converges at once, with no build and no pass. One request is
// worked at a time; s_axis_tready is high only while idle. The result register
// holds a finished result while m_axis_tready is low, and the next request may
// be accepted meanwhile; its result waits until the register frees up.
// Reset returns node_count to 1 and unreachable_cost to 999 and empties the
// result register; the memories are not cleared and read as undefined until
// written. Configuration is written through cfg_we_i; the user must write it
// only while idle, as the block itself does not enforce this.
module distance_vector_route_solver
  import dvrs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [COST_BITS-1:0] cfg_wdata_i,
  // Request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [1:0] action, [6:2] source_node, [11:7] dest_node, [21:12] link_cost
  input  logic [IN_BITS-1:0]   s_axis_tdata,
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] status, [11:2] route_cost, [16:12] next_hop, [17] has_hop, [18] unreachable
  output logic [OUT_BITS-1:0]  m_axis_tdata
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_COMPUTE,
    T_QUERY,
    T_EMIT
  } top_state_e;

  top_state_e            state_q, state_d;
  logic [CNT_BITS-1:0]   node_count_q;
  logic [COST_BITS-1:0]  unreach_q;
  logic [18:0]           res_q, res_d;
  logic                  out_vld_q, out_vld_d;
  logic [18:0]           out_q, out_d;

  logic [1:0]            in_action;
  logic [NODE_BITS-1:0]  in_src, in_dst;
  logic [COST_BITS-1:0]  in_cost;
  logic                  accept;
  logic                  q_re;
  logic                  eng_start, eng_done;
  mem_req_t              eng_req;
  logic [COST_BITS-1:0]  link_rdata;
  route_t                route_rdata;
  logic [ROUTE_BITS-1:0] route_rword;

  // Unpack the request
  assign in_action = s_axis_tdata[1:0];
  assign in_src    = s_axis_tdata[6:2];
  assign in_dst    = s_axis_tdata[11:7];
  assign in_cost   = s_axis_tdata[21:12];

  assign s_axis_tready = (state_q == T_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_re          = accept && (in_action == ACT_QUERY);
  assign eng_start     = accept && (in_action == ACT_COMPUTE);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_BITS'(1);
      unreach_q    <= COST_BITS'(999);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NODE_COUNT:  node_count_q <= cfg_wdata_i[CNT_BITS-1:0];
        CFG_UNREACHABLE: unreach_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Link cost matrix: written by requests, read by the engine
  dvrs_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (CELLS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (in_action == ACT_WRITE)),
    .waddr_i ({in_src, in_dst}),
    .wdata_i (in_cost),
    .re_i    (eng_req.link_re),
    .raddr_i (eng_req.link_raddr),
    .rdata_o (link_rdata)
  );

  // Routing table: written by the engine, read by the engine or a query
  dvrs_ram #(
    .WIDTH (ROUTE_BITS),
    .DEPTH (CELLS)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (eng_req.route_we),
    .waddr_i (eng_req.route_waddr),
    .wdata_i (eng_req.route_wdata),
    .re_i    (eng_req.route_re || q_re),
    .raddr_i (q_re ? {in_src, in_dst} : eng_req.route_raddr),
    .rdata_o (route_rword)
  );

  assign route_rdata = route_t'(route_rword);

  dvrs_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (eng_start),
    .node_count_i  (node_count_q),
    .unreach_i     (unreach_q),
    .link_rdata_i  (link_rdata),
    .route_rdata_i (route_rdata),
    .req_o         (eng_req),
    .done_o        (eng_done)
  );

  // Request sequencing and result register
  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;

    // Drop the result once taken
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_WRITE: begin
              res_d   = {17'd0, STS_WRITTEN};
              state_d = T_EMIT;
            end
            ACT_COMPUTE: state_d = T_COMPUTE;
            ACT_QUERY:   state_d = T_QUERY;
            default:     state_d = T_IDLE;
          endcase
        end
      end
      T_COMPUTE: begin
        if (eng_done) begin
          res_d   = {17'd0, STS_CONVERGED};
          state_d = T_EMIT;
        end
      end
      T_QUERY: begin
        res_d   = {(route_rdata.cost == unreach_q), route_rdata.valid,
                   (route_rdata.valid ? route_rdata.hop : NODE_BITS'(0)),
                   route_rdata.cost, STS_ANSWER};
        state_d = T_EMIT;
      end
      T_EMIT: begin
        // Move the result out when the register is free or being emptied
        if (!out_vld_q || m_axis_tready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_q};

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for distance_vector_route_solver: directed table, then random phases.
// Predicts every result with its own route solver; depends on dvrs_pkg and the RTL only.
module tb_top;
  import dvrs_pkg::*;

  // Action code that the block takes and drops
  localparam logic [1:0] ACT_SKIP = 2'd3;

  localparam int RANDOM_ITEMS  = 40;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  // Request layout, lowest bits first: action, source_node, dest_node, link_cost
  typedef struct packed {
    logic [1:0]           pad;
    logic [COST_BITS-1:0] link_cost;
    logic [NODE_BITS-1:0] dest_node;
    logic [NODE_BITS-1:0] source_node;
    logic [1:0]           action;
  } route_request_t;

  // Result layout, lowest bits first: status, route_cost, next_hop, has_hop, unreachable
  typedef struct packed {
    logic                 unreachable;
    logic                 has_hop;
    logic [NODE_BITS-1:0] next_hop;
    logic [COST_BITS-1:0] route_cost;
    logic [1:0]           status;
  } route_answer_t;

  // One line of the directed plan: a register write or a request
  typedef struct packed {
    logic                 is_cfg;
    logic                 cfg_idx;
    logic [COST_BITS-1:0] cfg_value;
    route_request_t       req;
    logic                 typed;
    route_answer_t        answer;
  } plan_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic                 cfg_idx_i     = 1'b0;
  logic [COST_BITS-1:0] cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_BITS-1:0]   s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]  m_axis_tdata;

  // Solver copy of the block state
  logic [COST_BITS-1:0] link_tbl   [MAX_NODES][MAX_NODES];
  logic                 link_known [MAX_NODES][MAX_NODES];
  route_t               route_tbl  [MAX_NODES][MAX_NODES];
  int                   route_span = 0;
  logic [5:0]           cfg_nodes  = 6'd1;
  logic [COST_BITS-1:0] cfg_unreach = 10'd999;

  route_answer_t pending_answers[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  logic          gaps_on     = 1'b1;
  logic          stalls_on   = 1'b1;
  logic          hold_wanted = 1'b0;

  distance_vector_route_solver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Build tables from direct costs, then relax in place until a pass is quiet
  function automatic void solve_routes();
    int   n;
    int   inf;
    int   a;
    int   b;
    int   held;
    logic changed;
    n   = (cfg_nodes > MAX_NODES) ? MAX_NODES : int'(cfg_nodes);
    inf = int'(cfg_unreach);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        route_tbl[i][j].cost  = link_tbl[i][j];
        route_tbl[i][j].valid = (link_tbl[i][j] != cfg_unreach) && (i != j);
        route_tbl[i][j].hop   = route_tbl[i][j].valid ? j[NODE_BITS-1:0] : '0;
      end
    end
    if (n > route_span) route_span = n;
    do begin
      changed = 1'b0;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          for (int k = 0; k < n; k++) begin
            a    = int'(link_tbl[i][k]);
            b    = int'(route_tbl[k][j].cost);
            held = int'(route_tbl[i][j].cost);
            if (a == inf || b == inf) continue;
            if (held > a + b) begin
              route_tbl[i][j].cost  = COST_BITS'(a + b);
              route_tbl[i][j].hop   = k[NODE_BITS-1:0];
              route_tbl[i][j].valid = 1'b1;
              changed = 1'b1;
            end
          end
        end
      end
    end while (changed);
  endfunction

  // Advance the solver by one request; return 1 when a result follows
  function automatic logic predict_answer(input route_request_t r, output route_answer_t ans);
    route_t entry;
    ans = '0;
    case (r.action)
      ACT_WRITE: begin
        link_tbl[r.source_node][r.dest_node]   = r.link_cost;
        link_known[r.source_node][r.dest_node] = 1'b1;
        ans.status = STS_WRITTEN;
      end
      ACT_COMPUTE: begin
        solve_routes();
        ans.status = STS_CONVERGED;
      end
      ACT_QUERY: begin
        entry           = route_tbl[r.source_node][r.dest_node];
        ans.status      = STS_ANSWER;
        ans.route_cost  = entry.cost;
        ans.has_hop     = entry.valid;
        ans.next_hop    = entry.valid ? entry.hop : '0;
        ans.unreachable = (entry.cost == cfg_unreach);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic route_request_t make_request(logic [1:0] act, int src, int dst, int cost);
    route_request_t r;
    r             = '0;
    r.action      = act;
    r.source_node = NODE_BITS'(src);
    r.dest_node   = NODE_BITS'(dst);
    r.link_cost   = COST_BITS'(cost);
    return r;
  endfunction

  function automatic plan_row_t req_row(logic [1:0] act, int src, int dst, int cost);
    plan_row_t row;
    row     = '0;
    row.req = make_request(act, src, dst, cost);
    return row;
  endfunction

  function automatic plan_row_t typed_row(logic [1:0] act, int src, int dst, int cost,
                                          logic [1:0] sts, int rc, int hop, int hv,
                                          int unr);
    plan_row_t row;
    row                    = req_row(act, src, dst, cost);
    row.typed              = 1'b1;
    row.answer.status      = sts;
    row.answer.route_cost  = COST_BITS'(rc);
    row.answer.next_hop    = NODE_BITS'(hop);
    row.answer.has_hop     = (hv != 0);
    row.answer.unreachable = (unr != 0);
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic idx, int value);
    plan_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.cfg_idx   = idx;
    row.cfg_value = COST_BITS'(value);
    return row;
  endfunction

  // Mix of no-link marks, short links and arbitrary costs
  function automatic int pick_cost();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return int'(cfg_unreach);
    if (sel < 75) return $urandom_range(0, 20);
    return $urandom_range(0, 1023);
  endfunction

  // Offer one request, hold it until taken, then record what it should produce
  task automatic send_request(input route_request_t r, input logic typed,
                              input route_answer_t typed_ans);
    route_answer_t ans;
    logic          gives;
    if (gaps_on && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    do @(posedge clk_i); while (!s_axis_tready);
    gives = predict_answer(r, ans);
    if (gives) pending_answers.push_back(typed ? typed_ans : ans);
  endtask

  // Drop valid and wait until every result is in and the block has settled
  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic idx, input int value);
    drain_requests();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= COST_BITS'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NODE_COUNT) cfg_nodes = 6'(value);
    else cfg_unreach = COST_BITS'(value);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_answer(input route_answer_t got);
    route_answer_t want;
    if (pending_answers.size() == 0) begin
      $error("result with nothing expected: %h", got);
      error_count++;
      return;
    end
    want = pending_answers.pop_front();
    check_field("status", int'(want.status), int'(got.status));
    check_field("route_cost", int'(want.route_cost), int'(got.route_cost));
    check_field("next_hop", int'(want.next_hop), int'(got.next_hop));
    check_field("has_hop", int'(want.has_hop), int'(got.has_hop));
    check_field("unreachable", int'(want.unreachable), int'(got.unreachable));
  endtask

  // Result side: check each taken result, stall at random, hold off on demand
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        check_answer(m_axis_tdata[$bits(route_answer_t)-1:0]);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(stalls_on && $urandom_range(99) < 33);
      end
    end
  end

  initial begin : stimulus
    plan_row_t      plan[$];
    route_request_t req;
    int             phase;
    int             mix_count;
    int             eff;
    int             pick;
    int             src;
    int             dst;
    phase     = 0;
    mix_count = 0;
    foreach (link_known[i, j]) link_known[i][j] = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: one node, unreachable at 999
    plan.push_back(typed_row(ACT_WRITE, 0, 0, 0, STS_WRITTEN, 0, 0, 0, 0));
    plan.push_back(typed_row(ACT_COMPUTE, 0, 0, 0, STS_CONVERGED, 0, 0, 0, 0));
    plan.push_back(typed_row(ACT_QUERY, 0, 0, 0, STS_ANSWER, 0, 0, 0, 0));
    plan.push_back(req_row(ACT_SKIP, 31, 31, 1023));
    // Zero nodes: converge at once, table untouched
    plan.push_back(cfg_row(CFG_NODE_COUNT, 0));
    plan.push_back(typed_row(ACT_COMPUTE, 0, 0, 0, STS_CONVERGED, 0, 0, 0, 0));
    plan.push_back(typed_row(ACT_QUERY, 0, 0, 0, STS_ANSWER, 0, 0, 0, 0));
    // Two nodes with the top cost as the no-link mark
    plan.push_back(cfg_row(CFG_UNREACHABLE, 1023));
    plan.push_back(cfg_row(CFG_NODE_COUNT, 2));
    plan.push_back(typed_row(ACT_WRITE, 0, 1, 1023, STS_WRITTEN, 0, 0, 0, 0));
    plan.push_back(typed_row(ACT_WRITE, 1, 0, 5, STS_WRITTEN, 0, 0, 0, 0));
    plan.push_back(typed_row(ACT_WRITE, 1, 1, 0, STS_WRITTEN, 0, 0, 0, 0));
    plan.push_back(typed_row(ACT_COMPUTE, 0, 0, 0, STS_CONVERGED, 0, 0, 0, 0));
    plan.push_back(typed_row(ACT_QUERY, 0, 1, 0, STS_ANSWER, 1023, 0, 0, 1));
    plan.push_back(typed_row(ACT_QUERY, 1, 0, 0, STS_ANSWER, 5, 0, 1, 0));
    plan.push_back(typed_row(ACT_WRITE, 31, 31, 1023, STS_WRITTEN, 0, 0, 0, 0));
    // Three nodes with the lowest mark; an old no-link cost turns finite
    plan.push_back(cfg_row(CFG_UNREACHABLE, 1));
    plan.push_back(cfg_row(CFG_NODE_COUNT, 3));
    plan.push_back(req_row(ACT_WRITE, 0, 2, 9));
    plan.push_back(req_row(ACT_WRITE, 1, 2, 3));
    plan.push_back(req_row(ACT_WRITE, 2, 0, 1));
    plan.push_back(req_row(ACT_WRITE, 2, 1, 1));
    plan.push_back(req_row(ACT_WRITE, 2, 2, 0));
    plan.push_back(req_row(ACT_COMPUTE, 0, 0, 0));
    plan.push_back(req_row(ACT_QUERY, 0, 2, 0));
    plan.push_back(req_row(ACT_QUERY, 2, 0, 0));

    foreach (plan[r]) begin
      if (plan[r].is_cfg) write_config(plan[r].cfg_idx, int'(plan[r].cfg_value));
      else send_request(plan[r].req, plan[r].typed, plan[r].answer);
    end

    // Random phases: new settings, complete the matrix, compute, then mixed traffic
    while (mix_count < RANDOM_ITEMS) begin
      gaps_on   = (phase != 1);
      stalls_on = (phase != 1);
      write_config(CFG_NODE_COUNT, $urandom_range(0, 7));
      case (phase % 3)
        0: write_config(CFG_UNREACHABLE, 1023);
        1: write_config(CFG_UNREACHABLE, $urandom_range(1, 1023));
        default: write_config(CFG_UNREACHABLE, 1);
      endcase
      eff = (cfg_nodes > MAX_NODES) ? MAX_NODES : int'(cfg_nodes);

      // Every link the compute reads must be written first
      for (int i = 0; i < eff; i++) begin
        for (int j = 0; j < eff; j++) begin
          if (!link_known[i][j])
            send_request(make_request(ACT_WRITE, i, j, pick_cost()), 1'b0, '0);
        end
      end
      send_request(make_request(ACT_COMPUTE, 0, 0, 0), 1'b0, '0);

      if (phase == 0) hold_wanted = 1'b1;
      repeat ($urandom_range(10, 25)) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          req = make_request(ACT_SKIP, $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 1023));
        end else if (pick < 30 && eff <= 8) begin
          req = make_request(ACT_COMPUTE, $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 1023));
        end else if (pick < 60) begin
          if (eff > 0 && $urandom_range(1)) begin
            src = $urandom_range(0, eff - 1);
            dst = $urandom_range(0, eff - 1);
          end else begin
            src = $urandom_range(0, 31);
            dst = $urandom_range(0, 31);
          end
          req = make_request(ACT_WRITE, src, dst, pick_cost());
        end else begin
          req = make_request(ACT_QUERY, $urandom_range(0, route_span - 1),
                             $urandom_range(0, route_span - 1), $urandom_range(0, 1023));
        end
        if (req.action != ACT_SKIP) mix_count++;
        send_request(req, 1'b0, '0);
      end
      phase++;
    end

    drain_requests();
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
hdl/dvrs_pkg.sv
hdl/dvrs_ram.sv
hdl/dvrs_engine.sv
hdl/distance_vector_route_solver.sv
verif/tb_top.sv
